[sv/fphs_pkg.sv]
// ============================================================================
// fphs_pkg: shared types and helpers of the four-point homography solver
// Holds the value formats, the arithmetic unit request and response
// structures, the sequencer state type, the magnitude helper and the saturating difference.
// ============================================================================
package fphs_pkg;

  // Value formats: matrix entries are signed with a 47-bit magnitude.
  localparam int VAL_W   = 48;
  localparam int MAG_W   = 47;
  localparam int COORD_W = 32;
  localparam int NUM_H   = 8;
  localparam int PT_W    = 5 * COORD_W;
  localparam int MX_DEPTH = 72;
  localparam int MX_AW   = 7;

  localparam logic [MAG_W-1:0] MAG_LIMIT = '1;
  localparam logic [1:0] LAST_SLOT = 2'd3;

  // Fraction format of a product handed to the multiplier.
  typedef enum logic [1:0] {
    MUL_COORD,
    MUL_CPROD,
    MUL_MPROD
  } mul_mode_t;

  typedef struct packed {
    logic             start;
    mul_mode_t        mode;
    logic             neg;
    logic [MAG_W-1:0] a_mag;
    logic [MAG_W-1:0] b_mag;
  } mul_req_t;

  typedef struct packed {
    logic                    start;
    logic signed [VAL_W-1:0] num;
    logic signed [VAL_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                    busy;
    logic                    done;
    logic                    sat;
    logic signed [VAL_W-1:0] value;
  } arith_rsp_t;

  typedef enum logic [4:0] {
    ENG_IDLE,
    ENG_B_RD,
    ENG_B_CALC,
    ENG_B_MUL,
    ENG_PV_RD,
    ENG_PV_CMP,
    ENG_PV_END,
    ENG_EL_RD1,
    ENG_EL_RD2,
    ENG_EL_CHK,
    ENG_EL_DIV,
    ENG_EL_J1,
    ENG_EL_J2,
    ENG_EL_MUL,
    ENG_BS_RD,
    ENG_BS_ACC,
    ENG_BS_J,
    ENG_BS_M,
    ENG_BS_MW,
    ENG_BS_DV,
    ENG_BS_DW,
    ENG_DONE
  } eng_state_t;

  // Magnitude of an entry; entries never hold the most negative code.
  function automatic logic [MAG_W-1:0] mag_of(input logic signed [VAL_W-1:0] v);
    logic [VAL_W-1:0] t;
    t = v[VAL_W-1] ? (VAL_W'(0) - v) : v;
    return t[MAG_W-1:0];
  endfunction

  // Saturating difference; the top bit of the result flags saturation.
  function automatic logic [VAL_W:0] sub_sat(input logic signed [VAL_W-1:0] a,
                                             input logic signed [VAL_W-1:0] b);
    logic signed [VAL_W:0] d;
    logic signed [VAL_W:0] lim;
    lim = $signed({2'b00, MAG_LIMIT});
    d = $signed({a[VAL_W-1], a}) - $signed({b[VAL_W-1], b});
    if (d > lim) begin
      return {1'b1, 1'b0, MAG_LIMIT};
    end else if (d < -lim) begin
      return {1'b1, VAL_W'(0) - {1'b0, MAG_LIMIT}};
    end
    return {1'b0, d[VAL_W-1:0]};
  endfunction

endpackage

[sv/fphs_mul.sv]
// ============================================================================
// fphs_mul: shared multi-cycle fixed point multiplier
// Forms the exact product of two magnitudes from four 24x24 partial
// products, then rescales it to the output format and saturates.
// ============================================================================
module fphs_mul
  import fphs_pkg::*;
#(
  parameter int COORD_FRAC_BITS = 16,
  parameter int OUT_FRAC_BITS   = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  input  mul_req_t   req,
  output arith_rsp_t rsp
);

  localparam int SH_C = COORD_FRAC_BITS - OUT_FRAC_BITS;
  localparam int RS_C = (SH_C > 0) ? SH_C : 0;
  localparam int LS_C = (SH_C < 0) ? -SH_C : 0;
  localparam int SH_P = 2 * COORD_FRAC_BITS - OUT_FRAC_BITS;
  localparam int RS_P = (SH_P > 0) ? SH_P : 0;
  localparam int LS_P = (SH_P < 0) ? -SH_P : 0;
  localparam int RS_M = OUT_FRAC_BITS;

  logic             busy_r, done_r, sat_r, neg_r;
  logic [2:0]       cnt_r;
  mul_mode_t        mode_r;
  logic [47:0]      a_r, b_r;
  logic [47:0]      pp_r;
  logic [1:0]       sh_r;
  logic [95:0]      acc_r;
  logic signed [VAL_W-1:0] val_r;

  logic [23:0]  op_a, op_b;
  logic [95:0]  pp_shift;
  logic [127:0] wide, scaled;
  logic         over;
  logic [MAG_W-1:0] m;

  // Operand halves for the partial product of this step:
  // lo*lo, lo*hi, hi*lo, hi*hi.
  always_comb begin
    op_a = cnt_r[1] ? a_r[47:24] : a_r[23:0];
    op_b = cnt_r[0] ? b_r[47:24] : b_r[23:0];
  end

  always_comb begin
    case (sh_r)
      2'd0:    pp_shift = {48'b0, pp_r};
      2'd1:    pp_shift = {24'b0, pp_r, 24'b0};
      default: pp_shift = {pp_r, 48'b0};
    endcase
  end

  // Rescale the exact product and clamp its magnitude.
  always_comb begin
    wide = {32'b0, acc_r};
    case (mode_r)
      MUL_COORD: scaled = (wide >> RS_C) << LS_C;
      MUL_CPROD: scaled = (wide >> RS_P) << LS_P;
      default:   scaled = wide >> RS_M;
    endcase
    over = |scaled[127:MAG_W];
    m = over ? MAG_LIMIT : scaled[MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 3'd0;
        acc_r  <= '0;
        a_r    <= {1'b0, req.a_mag};
        b_r    <= {1'b0, req.b_mag};
        neg_r  <= req.neg;
        mode_r <= req.mode;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r <= 3'd3) begin
          pp_r <= op_a * op_b;
          sh_r <= 2'(cnt_r[1]) + 2'(cnt_r[0]);
        end
        if (cnt_r >= 3'd1 && cnt_r <= 3'd4) begin
          acc_r <= acc_r + pp_shift;
        end
        if (cnt_r == 3'd5) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          sat_r  <= over;
          val_r  <= neg_r ? (VAL_W'(0) - {1'b0, m}) : {1'b0, m};
        end
      end
    end
  end

  assign rsp.busy  = busy_r;
  assign rsp.done  = done_r;
  assign rsp.sat   = sat_r;
  assign rsp.value = val_r;

endmodule

[sv/fphs_div.sv]
// ============================================================================
// fphs_div: shared restoring divider
// Produces the fixed point quotient one bit per cycle and flags a quotient
// whose magnitude does not fit.
// ============================================================================
module fphs_div
  import fphs_pkg::*;
#(
  parameter int OUT_FRAC_BITS = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  input  div_req_t   req,
  output arith_rsp_t rsp
);

  localparam int NB = MAG_W + OUT_FRAC_BITS;
  localparam int CW = $clog2(NB + 1);

  logic [NB-1:0]    dvd_r;
  logic [MAG_W-1:0] rem_r, dm_r, q_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r, done_r, sat_r, ovf_r, neg_r;
  logic signed [VAL_W-1:0] val_r;

  logic [MAG_W:0]   rem_sh, rem_diff;
  logic             ge;
  logic [MAG_W-1:0] qm;

  // One restoring step: bring down the next dividend bit and try a subtract.
  assign rem_sh   = {rem_r, dvd_r[NB-1]};
  assign ge       = (rem_sh >= {1'b0, dm_r});
  assign rem_diff = rem_sh - {1'b0, dm_r};
  assign qm       = ovf_r ? MAG_LIMIT : q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        dvd_r  <= {mag_of(req.num), {OUT_FRAC_BITS{1'b0}}};
        dm_r   <= mag_of(req.den);
        rem_r  <= '0;
        q_r    <= '0;
        ovf_r  <= 1'b0;
        neg_r  <= req.num[VAL_W-1] ^ req.den[VAL_W-1];
        cnt_r  <= CW'(NB);
      end else if (busy_r) begin
        if (cnt_r != '0) begin
          rem_r <= ge ? rem_diff[MAG_W-1:0] : rem_sh[MAG_W-1:0];
          q_r   <= {q_r[MAG_W-2:0], ge};
          ovf_r <= ovf_r | q_r[MAG_W-1];
          dvd_r <= dvd_r << 1;
          cnt_r <= cnt_r - CW'(1);
        end else begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          sat_r  <= ovf_r;
          val_r  <= neg_r ? (VAL_W'(0) - {1'b0, qm}) : {1'b0, qm};
        end
      end
    end
  end

  assign rsp.busy  = busy_r;
  assign rsp.done  = done_r;
  assign rsp.sat   = sat_r;
  assign rsp.value = val_r;

endmodule

[sv/fphs_engine.sv]
// ============================================================================
// fphs_engine: point store, work matrix and solve sequencer
// Keeps the points and the 8x9 system in synchronous memories and walks
// build, pivoted elimination and back substitution through them.
// ============================================================================
module fphs_engine
  import fphs_pkg::*;
#(
  parameter int COORD_FRAC_BITS = 16,
  parameter int OUT_FRAC_BITS   = 24
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_slot,
  input  logic [PT_W-1:0]           in_coords,
  output logic                      res_valid,
  input  logic                      res_ready,
  output logic [NUM_H-1:0][VAL_W-1:0] res_h,
  output logic                      res_failed
);

  eng_state_t state_r, state_nxt;
  logic [2:0] k_r, k_nxt, r_r, r_nxt, piv_r, piv_nxt, pivphys_r, pivphys_nxt;
  logic [3:0] j_r, j_nxt;
  logic [1:0] i_r, i_nxt;
  logic [4:0] e_r, e_nxt;
  logic [MAG_W-1:0] best_r, best_nxt;
  logic signed [VAL_W-1:0] tmp_r, tmp_nxt, f_r, f_nxt, acc_r, acc_nxt;
  logic sat_r, sat_nxt, sing_r, sing_nxt;

  logic [2:0] perm_r [NUM_H];
  logic signed [VAL_W-1:0] h_r [NUM_H];
  logic [2:0] rdphys_r;

  // Memories and their ports.
  logic [PT_W-1:0]  pt_mem [4];
  logic [PT_W-1:0]  pt_rd_r;
  logic             pt_wr_en, pt_rd_en;
  logic [VAL_W-1:0] mx_mem [MX_DEPTH];
  logic signed [VAL_W-1:0] mx_rd_r;
  logic             mx_rd_en, mx_wr_en, mx_wr_lin;
  logic [3:0]       mx_col;
  logic [MX_AW-1:0] mx_addr;
  logic [VAL_W-1:0] mx_wr_data;

  logic       use_r, perm_init, perm_swap, h_we;
  logic [2:0] phys;

  mul_req_t   mul_req;
  div_req_t   div_req;
  arith_rsp_t mul_rsp, div_rsp;

  logic       row1;
  logic [3:0] c;
  logic [31:0] ca, cb;
  logic       b_zero, b_conv, b_negate;
  mul_mode_t  b_mode;
  logic       b_last;
  logic [VAL_W:0] sd;

  function automatic logic [31:0] pick(input logic [PT_W-1:0] pt, input logic [2:0] idx);
    case (idx)
      3'd0:    return pt[31:0];
      3'd1:    return pt[63:32];
      3'd2:    return pt[95:64];
      3'd3:    return pt[127:96];
      default: return pt[159:128];
    endcase
  endfunction

  function automatic logic [31:0] cmag(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  fphs_mul #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS),
    .OUT_FRAC_BITS  (OUT_FRAC_BITS)
  ) u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mul_req),
    .rsp  (mul_rsp)
  );

  fphs_div #(
    .OUT_FRAC_BITS(OUT_FRAC_BITS)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  // Row permutation lookup: one logical row per cycle.
  assign phys = perm_r[use_r ? r_r : k_r];

  // Matrix address: linear during build, permuted row and column otherwise.
  always_comb begin
    if (mx_wr_lin) begin
      mx_addr = MX_AW'({i_r, 4'b0000}) + MX_AW'({i_r, 1'b0}) + MX_AW'(e_r);
    end else begin
      mx_addr = MX_AW'({phys, 3'b000}) + MX_AW'(phys) + MX_AW'(mx_col);
    end
  end

  always_ff @(posedge clk) begin
    if (pt_wr_en) begin
      pt_mem[in_slot] <= in_coords;
    end
    if (pt_rd_en) begin
      pt_rd_r <= pt_mem[i_r];
    end
    if (mx_wr_en) begin
      mx_mem[mx_addr] <= mx_wr_data;
    end
    if (mx_rd_en) begin
      mx_rd_r  <= mx_mem[mx_addr];
      rdphys_r <= phys;
    end
  end

  // Entry of the two rows of one point, selected by the build counter.
  always_comb begin
    row1     = (e_r >= 5'd9);
    c        = row1 ? 4'(e_r - 5'd9) : e_r[3:0];
    b_zero   = 1'b0;
    b_conv   = 1'b0;
    b_negate = 1'b0;
    b_mode   = MUL_CPROD;
    ca       = pick(pt_rd_r, 3'd0);
    cb       = 32'd1;
    if (c < 4'd3) begin
      b_zero = row1;
      b_conv = 1'b1;
      ca     = pick(pt_rd_r, c[2:0]);
    end else if (c < 4'd6) begin
      b_zero = !row1;
      b_conv = 1'b1;
      ca     = pick(pt_rd_r, 3'(c - 4'd3));
    end else if (c < 4'd8) begin
      b_negate = 1'b1;
      ca       = pick(pt_rd_r, 3'(c - 4'd6));
      cb       = row1 ? pick(pt_rd_r, 3'd4) : pick(pt_rd_r, 3'd3);
    end else begin
      ca = row1 ? pick(pt_rd_r, 3'd4) : pick(pt_rd_r, 3'd3);
      cb = pick(pt_rd_r, 3'd2);
    end
    if (b_conv) begin
      b_mode = MUL_COORD;
      cb     = 32'd1;
    end
    b_last = (e_r == 5'd17);
  end

  // Sequencer: next state, counters and unit requests.
  always_comb begin
    state_nxt   = state_r;
    k_nxt       = k_r;
    r_nxt       = r_r;
    j_nxt       = j_r;
    i_nxt       = i_r;
    e_nxt       = e_r;
    piv_nxt     = piv_r;
    pivphys_nxt = pivphys_r;
    best_nxt    = best_r;
    tmp_nxt     = tmp_r;
    f_nxt       = f_r;
    acc_nxt     = acc_r;
    sat_nxt     = sat_r;
    sing_nxt    = sing_r;
    in_ready    = 1'b0;
    res_valid   = 1'b0;
    pt_wr_en    = 1'b0;
    pt_rd_en    = 1'b0;
    mx_rd_en    = 1'b0;
    mx_wr_en    = 1'b0;
    mx_wr_lin   = 1'b0;
    mx_col      = {1'b0, k_r};
    mx_wr_data  = '0;
    use_r       = 1'b0;
    perm_init   = 1'b0;
    perm_swap   = 1'b0;
    h_we        = 1'b0;
    mul_req     = '0;
    div_req     = '0;
    sd          = '0;
    case (state_r)
      ENG_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          pt_wr_en = 1'b1;
          if (in_slot == LAST_SLOT) begin
            sat_nxt   = 1'b0;
            sing_nxt  = 1'b0;
            i_nxt     = 2'd0;
            e_nxt     = 5'd0;
            state_nxt = ENG_B_RD;
          end
        end
      end
      // Build the two rows of each point.
      ENG_B_RD: begin
        pt_rd_en  = 1'b1;
        state_nxt = ENG_B_CALC;
      end
      ENG_B_CALC, ENG_B_MUL: begin
        mx_wr_lin = 1'b1;
        if (state_r == ENG_B_CALC && !b_zero) begin
          mul_req.start = 1'b1;
          mul_req.mode  = b_mode;
          mul_req.neg   = ca[31] ^ cb[31] ^ b_negate;
          mul_req.a_mag = MAG_W'(cmag(ca));
          mul_req.b_mag = MAG_W'(cmag(cb));
          state_nxt     = ENG_B_MUL;
        end else if (state_r == ENG_B_CALC || mul_rsp.done) begin
          mx_wr_en = 1'b1;
          if (state_r == ENG_B_MUL) begin
            mx_wr_data = mul_rsp.value;
            sat_nxt    = sat_r | mul_rsp.sat;
          end
          if (!b_last) begin
            e_nxt     = e_r + 5'd1;
            state_nxt = ENG_B_CALC;
          end else if (i_r != 2'd3) begin
            e_nxt     = 5'd0;
            i_nxt     = i_r + 2'd1;
            state_nxt = ENG_B_RD;
          end else begin
            perm_init = 1'b1;
            k_nxt     = 3'd0;
            r_nxt     = 3'd0;
            state_nxt = ENG_PV_RD;
          end
        end
      end
      // Pivot search down column k.
      ENG_PV_RD: begin
        use_r     = 1'b1;
        mx_rd_en  = 1'b1;
        state_nxt = ENG_PV_CMP;
      end
      ENG_PV_CMP: begin
        if (r_r == k_r || mag_of(mx_rd_r) > best_r) begin
          best_nxt    = mag_of(mx_rd_r);
          piv_nxt     = r_r;
          pivphys_nxt = rdphys_r;
        end
        if (r_r == 3'd7) begin
          state_nxt = ENG_PV_END;
        end else begin
          r_nxt     = r_r + 3'd1;
          state_nxt = ENG_PV_RD;
        end
      end
      ENG_PV_END: begin
        if (best_r == '0) begin
          sing_nxt  = 1'b1;
          state_nxt = ENG_DONE;
        end else begin
          perm_swap = 1'b1;
          if (k_r == 3'd7) begin
            state_nxt = ENG_BS_RD;
          end else begin
            r_nxt     = k_r + 3'd1;
            state_nxt = ENG_EL_RD1;
          end
        end
      end
      // Eliminate column k from row r.
      ENG_EL_RD1: begin
        use_r     = 1'b1;
        mx_rd_en  = 1'b1;
        state_nxt = ENG_EL_RD2;
      end
      ENG_EL_RD2: begin
        tmp_nxt   = mx_rd_r;
        mx_rd_en  = 1'b1;
        state_nxt = ENG_EL_CHK;
      end
      ENG_EL_CHK: begin
        if (tmp_r == '0) begin
          if (r_r == 3'd7) begin
            k_nxt     = k_r + 3'd1;
            r_nxt     = k_r + 3'd1;
            state_nxt = ENG_PV_RD;
          end else begin
            r_nxt     = r_r + 3'd1;
            state_nxt = ENG_EL_RD1;
          end
        end else begin
          div_req.start = 1'b1;
          div_req.num   = tmp_r;
          div_req.den   = mx_rd_r;
          state_nxt     = ENG_EL_DIV;
        end
      end
      ENG_EL_DIV: begin
        if (div_rsp.done) begin
          f_nxt     = div_rsp.value;
          sat_nxt   = sat_r | div_rsp.sat;
          j_nxt     = {1'b0, k_r} + 4'd1;
          state_nxt = ENG_EL_J1;
        end
      end
      ENG_EL_J1: begin
        mx_col    = j_r;
        mx_rd_en  = 1'b1;
        state_nxt = ENG_EL_J2;
      end
      ENG_EL_J2: begin
        mul_req.start = 1'b1;
        mul_req.mode  = MUL_MPROD;
        mul_req.neg   = f_r[VAL_W-1] ^ mx_rd_r[VAL_W-1];
        mul_req.a_mag = mag_of(f_r);
        mul_req.b_mag = mag_of(mx_rd_r);
        use_r         = 1'b1;
        mx_col        = j_r;
        mx_rd_en      = 1'b1;
        state_nxt     = ENG_EL_MUL;
      end
      ENG_EL_MUL: begin
        use_r  = 1'b1;
        mx_col = j_r;
        if (mul_rsp.done) begin
          sd         = sub_sat(mx_rd_r, mul_rsp.value);
          mx_wr_en   = 1'b1;
          mx_wr_data = sd[VAL_W-1:0];
          sat_nxt    = sat_r | sd[VAL_W] | mul_rsp.sat;
          if (j_r != 4'd8) begin
            j_nxt     = j_r + 4'd1;
            state_nxt = ENG_EL_J1;
          end else if (r_r == 3'd7) begin
            k_nxt     = k_r + 3'd1;
            r_nxt     = k_r + 3'd1;
            state_nxt = ENG_PV_RD;
          end else begin
            r_nxt     = r_r + 3'd1;
            state_nxt = ENG_EL_RD1;
          end
        end
      end
      // Back substitution from the last row up.
      ENG_BS_RD: begin
        mx_col    = 4'd8;
        mx_rd_en  = 1'b1;
        state_nxt = ENG_BS_ACC;
      end
      ENG_BS_ACC: begin
        acc_nxt   = mx_rd_r;
        j_nxt     = {1'b0, k_r} + 4'd1;
        state_nxt = ENG_BS_J;
      end
      ENG_BS_J: begin
        mx_rd_en = 1'b1;
        if (j_r == 4'd8) begin
          state_nxt = ENG_BS_DV;
        end else begin
          mx_col    = j_r;
          state_nxt = ENG_BS_M;
        end
      end
      ENG_BS_M: begin
        mul_req.start = 1'b1;
        mul_req.mode  = MUL_MPROD;
        mul_req.neg   = mx_rd_r[VAL_W-1] ^ h_r[j_r[2:0]][VAL_W-1];
        mul_req.a_mag = mag_of(mx_rd_r);
        mul_req.b_mag = mag_of(h_r[j_r[2:0]]);
        state_nxt     = ENG_BS_MW;
      end
      ENG_BS_MW: begin
        if (mul_rsp.done) begin
          sd        = sub_sat(acc_r, mul_rsp.value);
          acc_nxt   = sd[VAL_W-1:0];
          sat_nxt   = sat_r | sd[VAL_W] | mul_rsp.sat;
          j_nxt     = j_r + 4'd1;
          state_nxt = ENG_BS_J;
        end
      end
      ENG_BS_DV: begin
        div_req.start = 1'b1;
        div_req.num   = acc_r;
        div_req.den   = mx_rd_r;
        state_nxt     = ENG_BS_DW;
      end
      ENG_BS_DW: begin
        if (div_rsp.done) begin
          h_we    = 1'b1;
          sat_nxt = sat_r | div_rsp.sat;
          if (k_r == 3'd0) begin
            state_nxt = ENG_DONE;
          end else begin
            k_nxt     = k_r - 3'd1;
            state_nxt = ENG_BS_RD;
          end
        end
      end
      ENG_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ENG_IDLE;
        end
      end
      default: begin
        state_nxt = ENG_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ENG_IDLE;
      sat_r   <= 1'b0;
      sing_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sat_r   <= sat_nxt;
      sing_r  <= sing_nxt;
    end
  end

  // Counters, working values, permutation and solution registers.
  always_ff @(posedge clk) begin
    k_r       <= k_nxt;
    r_r       <= r_nxt;
    j_r       <= j_nxt;
    i_r       <= i_nxt;
    e_r       <= e_nxt;
    piv_r     <= piv_nxt;
    pivphys_r <= pivphys_nxt;
    best_r    <= best_nxt;
    tmp_r     <= tmp_nxt;
    f_r       <= f_nxt;
    acc_r     <= acc_nxt;
    if (perm_init) begin
      for (int n = 0; n < NUM_H; n++) begin
        perm_r[n] <= 3'(n);
      end
    end
    // A pivot already in place leaves the permutation unchanged.
    if (perm_swap && piv_r != k_r) begin
      perm_r[piv_r] <= phys;
      perm_r[k_r]   <= pivphys_r;
    end
    if (h_we) begin
      h_r[k_r] <= div_rsp.value;
    end
  end

  // Result: a singular system gives all-zero entries.
  always_comb begin
    for (int n = 0; n < NUM_H; n++) begin
      res_h[n] = sing_r ? '0 : h_r[n];
    end
  end
  assign res_failed = sing_r | sat_r;

  // The matrix is never written while waiting for a point.
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ENG_IDLE |-> !mx_wr_en)
    else $error("work matrix written while idle");

  // The shared units are never restarted while busy.
  a_mul_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    mul_req.start |-> !mul_rsp.busy)
    else $error("multiplier started while busy");

  a_div_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // A divider result is never ready the cycle after its start.
  a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |=> !div_rsp.done)
    else $error("divider answered too early");

endmodule

[sv/four_point_homography_solver.sv]
// A point in slots 0 to 2 is taken while the sequencer is idle; a slot 3
// point also starts a solve, and no further point is taken until its result
// is handed on. The solve time is set by the serial divider, which forms up to
// 36 quotients, and by the multiplier on the single-port work matrix.
// One point is taken at a time; a result waits in the output register.
// Reset (synchronous, active low) empties the output register and idles the
// sequencer; stored points are not cleared.
// ============================================================================
// four_point_homography_solver: four-point homography solver, top level
// Takes four correspondences as stream transactions and returns the first
// eight homography entries with a failure flag after each slot 3 point.
// ============================================================================
module four_point_homography_solver
  import fphs_pkg::*;
#(
  parameter int COORD_FRAC_BITS = 16,
  parameter int OUT_FRAC_BITS   = 24
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [159:0] in_tdata,   // src_u, src_v, src_w, dst_x, dst_y
  input  logic [1:0]   in_tuser,   // point_slot
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [383:0] out_tdata,  // h_r0c0, h_r0c1, h_r0c2, h_r1c0, h_r1c1,
                                   // h_r1c2, h_r2c0, h_r2c1
  output logic [0:0]   out_tuser   // solve_failed
);

  logic                        res_valid, res_ready, res_failed;
  logic [NUM_H-1:0][VAL_W-1:0] res_h;
  logic                        out_tvalid_r;
  logic [383:0]                out_tdata_r;
  logic [0:0]                  out_tuser_r;

  fphs_engine #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS),
    .OUT_FRAC_BITS  (OUT_FRAC_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_slot   (in_tuser),
    .in_coords (in_tdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_h     (res_h),
    .res_failed(res_failed)
  );

  // Output register: loads when empty or when its transaction completes.
  assign res_ready = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_tdata_r <= res_h;
      out_tuser_r <= res_failed;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb: self-checking testbench of the four-point homography solver
// Sends correspondences as stream transactions, predicts every result with
// a fixed-point model of the pivoted elimination and checks each result
// transaction field by field against the oldest prediction.
// ============================================================================
module tb
  import fphs_pkg::*;
();

  localparam int CFB = 16;
  localparam int OFB = 24;
  localparam logic [127:0] LIM = (128'd1 << 47) - 1;
  localparam logic [31:0] ONE_Q = 32'h0001_0000;

  typedef struct packed {
    logic [383:0] h;
    logic         failed;
  } homography_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [159:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [383:0] out_tdata;
  logic [0:0]   out_tuser;

  // Predictor state: stored points and the saturation seen during a solve.
  longint      stored_pt[20];
  bit          sat_flag;
  homography_t expected_h[$];
  int          errors = 0;
  int          items_sent = 0;
  int          burst_left = 0;
  int          hold_requests = 0;
  int          hold_served = 0;

  four_point_homography_solver dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Fixed-point helpers of the predictor.
  function automatic logic [63:0] mag64(input longint v);
    return 64'(v < 0 ? -v : v);
  endfunction

  function automatic longint fx_pack(input bit neg, input logic [127:0] m_in,
                                     input int frac_in);
    logic [127:0] m;
    if (frac_in >= OFB) begin
      m = m_in >> (frac_in - OFB);
    end else begin
      m = m_in << (OFB - frac_in);
    end
    if (m > LIM) begin
      sat_flag = 1'b1;
      m = LIM;
    end
    return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
  endfunction

  function automatic longint fx_mul(input longint a, input longint b, input int frac_in);
    logic [127:0] p;
    p = {64'd0, mag64(a)} * {64'd0, mag64(b)};
    return fx_pack((a < 0) != (b < 0), p, frac_in);
  endfunction

  function automatic longint fx_sub(input longint a, input longint b);
    longint d;
    d = a - b;
    if (d > longint'(LIM)) begin
      sat_flag = 1'b1;
      d = longint'(LIM);
    end
    if (d < -longint'(LIM)) begin
      sat_flag = 1'b1;
      d = -longint'(LIM);
    end
    return d;
  endfunction

  function automatic longint fx_div(input longint n, input longint d);
    logic [63:0]  nm, dm, q0;
    logic [127:0] q;
    nm = mag64(n);
    dm = mag64(d);
    q0 = nm / dm;
    if ({64'd0, q0} > (LIM >> OFB)) begin
      sat_flag = 1'b1;
      q = LIM;
    end else begin
      q = ({64'd0, nm} << OFB) / {64'd0, dm};
      if (q > LIM) begin
        sat_flag = 1'b1;
        q = LIM;
      end
    end
    return ((n < 0) != (d < 0)) ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  // Builds the 8x9 system from the stored points and solves it.
  function automatic homography_t solve_homography();
    longint      a[72];
    longint      h[8];
    longint      t, f, acc;
    logic [63:0] best, m;
    int          piv;
    bit          singular;
    homography_t res;
    singular = 1'b0;
    sat_flag = 1'b0;
    foreach (a[i]) a[i] = 0;
    foreach (h[i]) h[i] = 0;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 3; j++) begin
        t = fx_pack(stored_pt[i*5+j] < 0, {64'd0, mag64(stored_pt[i*5+j])}, CFB);
        a[(2*i)*9 + j] = t;
        a[(2*i+1)*9 + 3 + j] = t;
      end
      for (int j = 0; j < 2; j++) begin
        a[(2*i)*9 + 6 + j]   = -fx_mul(stored_pt[i*5+j], stored_pt[i*5+3], 2*CFB);
        a[(2*i+1)*9 + 6 + j] = -fx_mul(stored_pt[i*5+j], stored_pt[i*5+4], 2*CFB);
      end
      a[(2*i)*9 + 8]   = fx_mul(stored_pt[i*5+3], stored_pt[i*5+2], 2*CFB);
      a[(2*i+1)*9 + 8] = fx_mul(stored_pt[i*5+4], stored_pt[i*5+2], 2*CFB);
    end
    // Forward elimination; the lowest row of largest magnitude is the pivot.
    for (int k = 0; k < 8 && !singular; k++) begin
      piv = k;
      best = mag64(a[k*9+k]);
      for (int r = k + 1; r < 8; r++) begin
        m = mag64(a[r*9+k]);
        if (m > best) begin
          best = m;
          piv = r;
        end
      end
      if (best == 0) begin
        singular = 1'b1;
      end else begin
        if (piv != k) begin
          for (int j = 0; j < 9; j++) begin
            t = a[k*9+j];
            a[k*9+j] = a[piv*9+j];
            a[piv*9+j] = t;
          end
        end
        for (int r = k + 1; r < 8; r++) begin
          if (a[r*9+k] != 0) begin
            f = fx_div(a[r*9+k], a[k*9+k]);
            for (int j = k + 1; j < 9; j++)
              a[r*9+j] = fx_sub(a[r*9+j], fx_mul(f, a[k*9+j], 2*OFB));
            a[r*9+k] = 0;
          end
        end
      end
    end
    // Back substitution.
    if (!singular) begin
      for (int k = 7; k >= 0; k--) begin
        acc = a[k*9+8];
        for (int j = k + 1; j < 8; j++)
          acc = fx_sub(acc, fx_mul(a[k*9+j], h[j], 2*OFB));
        h[k] = fx_div(acc, a[k*9+k]);
      end
    end else begin
      foreach (h[i]) h[i] = 0;
    end
    for (int j = 0; j < 8; j++) res.h[48*j +: 48] = h[j][47:0];
    res.failed = singular || sat_flag;
    return res;
  endfunction

  // Sends one correspondence; the valid is left high for a following item.
  task automatic send_point(input logic [1:0] slot, input logic [31:0] u,
                            input logic [31:0] v, input logic [31:0] w,
                            input logic [31:0] x, input logic [31:0] y);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= slot;
    in_tdata  <= {y, x, w, v, u};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    stored_pt[slot*5+0] = longint'(signed'(u));
    stored_pt[slot*5+1] = longint'(signed'(v));
    stored_pt[slot*5+2] = longint'(signed'(w));
    stored_pt[slot*5+3] = longint'(signed'(x));
    stored_pt[slot*5+4] = longint'(signed'(y));
    if (slot == LAST_SLOT) expected_h.push_back(solve_homography());
    items_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_h.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord(input int kind);
    logic [31:0] corner[5];
    corner = '{32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h1};
    case (kind)
      0: return 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
      1: return $urandom();
      default: return corner[$urandom_range(0, 4)];
    endcase
  endfunction

  // One set of correspondences ending in a solve.
  task automatic send_random_set();
    int kind, k;
    logic [1:0] order[3];
    kind = ($urandom_range(0, 9) < 8) ? 0 : $urandom_range(1, 2);
    order = '{2'd0, 2'd1, 2'd2};
    order.shuffle();
    foreach (order[i]) begin
      // Slots may be skipped and reused, or written twice.
      if ($urandom_range(0, 9) < 8) begin
        k = ($urandom_range(0, 9) == 0) ? 2 : 1;
        repeat (k) send_point(order[i], rand_coord(kind), rand_coord(kind),
                              ($urandom_range(0, 3) == 0) ? rand_coord(kind) : ONE_Q,
                              rand_coord(kind), rand_coord(kind));
      end
    end
    send_point(LAST_SLOT, rand_coord(kind), rand_coord(kind),
               ($urandom_range(0, 3) == 0) ? rand_coord(kind) : ONE_Q,
               rand_coord(kind), rand_coord(kind));
  endtask

  // A unit square mapped to a shifted and scaled square.
  task automatic test_basic();
    send_point(2'd0, 32'h0, 32'h0, ONE_Q, 32'h0001_0000, 32'h0002_0000);
    send_point(2'd1, ONE_Q, 32'h0, ONE_Q, 32'h0003_0000, 32'h0002_0000);
    send_point(2'd2, ONE_Q, ONE_Q, ONE_Q, 32'h0003_0000, 32'h0004_0000);
    send_point(2'd3, 32'h0, ONE_Q, ONE_Q, 32'h0001_0000, 32'h0004_0000);
  endtask

  // Extreme coordinates, which saturate, and a reused slot set.
  task automatic test_extremes();
    send_point(2'd0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
               32'h7fff_ffff);
    send_point(2'd3, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
               32'h8000_0000);
    send_point(2'd3, 32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff, 32'h0000_0001,
               32'hffff_ffff);
  endtask

  // All-zero points give a zero pivot column.
  task automatic test_singular();
    for (int s = 0; s < 4; s++) send_point(2'(s), 0, 0, 0, 0, 0);
    for (int s = 0; s < 4; s++) send_point(2'(s), ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q);
  endtask

  // Equal magnitudes of opposite sign compete for the pivot.
  task automatic test_pivot_ties();
    send_point(2'd0, ONE_Q, ONE_Q, ONE_Q, 32'h0002_0000, 32'h0);
    send_point(2'd1, -ONE_Q, ONE_Q, ONE_Q, 32'hfffe_0000, 32'h0);
    send_point(2'd2, ONE_Q, -ONE_Q, ONE_Q, 32'h0, 32'h0002_0000);
    send_point(2'd3, -ONE_Q, -ONE_Q, ONE_Q, 32'h0, 32'hfffe_0000);
  endtask

  // The receiver holds off for a long stretch while points keep coming.
  task automatic test_long_hold();
    hold_requests++;
    repeat (3) send_random_set();
  endtask

  task automatic test_random();
    while (items_sent < 1850) begin
      send_random_set();
      if ($urandom_range(0, 49) == 0) wait_drained();
    end
  endtask

  // Receiver: stall pattern in modes, plus the long hold.
  int hold_left = 0;
  int ready_mode = 0;
  int mode_left = 0;
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= 20000;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode <= $urandom_range(0, 2);
        mode_left <= $urandom_range(50, 3000);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (ready_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= $urandom_range(0, 1);
        default: out_tready <= ($urandom_range(0, 15) == 0);
      endcase
    end
  end

  // Result checking against the oldest prediction.
  homography_t got, want;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got.h = out_tdata;
      got.failed = out_tuser[0];
      if (expected_h.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        want = expected_h.pop_front();
        for (int j = 0; j < 8; j++) begin
          if (got.h[48*j +: 48] !== want.h[48*j +: 48]) begin
            $error("h_r%0dc%0d: expected %h, got %h", j / 3, j % 3,
                   want.h[48*j +: 48], got.h[48*j +: 48]);
            errors++;
          end
        end
        if (got.failed !== want.failed) begin
          $error("solve_failed: expected %b, got %b", want.failed, got.failed);
          errors++;
        end
      end
    end
  end

  initial begin
    foreach (stored_pt[i]) stored_pt[i] = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic();
    test_singular();
    test_extremes();
    test_pivot_ties();
    wait_drained();
    test_long_hold();
    wait_drained();
    test_random();
    wait_drained();
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_h.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Overall time limit.
  initial begin
    #200_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
